FILE: rtl/rle_pkg.sv
`default_nettype none

package rle_pkg;

    // Lanes per output beat; out_lanes carries at most eight bytes.
    localparam int LANES = 8;
    localparam int GROUP = (LANES > 8) ? 8 : ((LANES < 1) ? 1 : LANES);
    localparam int OUT_LANES = 8;

    localparam logic [7:0] TAG_RUN = 8'd1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_CUT_HEADER  = 3'd1;
    localparam logic [2:0] ST_CUT_VALUE   = 3'd2;
    localparam logic [2:0] ST_CUT_LITERAL = 3'd3;
    localparam logic [2:0] ST_SIZE        = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One unit of work for the back end: count copies of value (a literal
    // byte is a run of one), then an optional frame-end beat.
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] count;
        logic       frame_end;
        logic [2:0] status;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/rle_fifo.sv
`default_nettype none

module rle_fifo
    import rle_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head_cmd,
    output logic      empty,
    output logic      full
);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("queue popped while empty");
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> (!full || pop))
        else $error("queue pushed while full");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("queue fill count lost a push");

endmodule

`default_nettype wire

FILE: rtl/rle_front.sv
`default_nettype none

module rle_front
    import rle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_byte,
    output logic             push,
    output cmd_t             push_cmd
);

    localparam logic [1:0] PH_TAG   = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_LIT   = 2'd3;

    logic [31:0] expected_reg;
    logic [1:0]  phase_reg, phase_next;
    logic        run_reg, run_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic [31:0] total_reg, total_next;
    logic [7:0]  addend;
    logic [32:0] sum;
    logic [31:0] total_sat;

    assign sum       = {1'b0, total_reg} + {25'd0, addend};
    assign total_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    always_comb begin
        phase_next         = phase_reg;
        run_next           = run_reg;
        remaining_next     = remaining_reg;
        addend             = 8'd0;
        push_cmd.value     = in_byte;
        push_cmd.count     = 8'd0;
        push_cmd.frame_end = 1'b0;
        push_cmd.status    = ST_OK;

        unique case (phase_reg)
            PH_TAG: begin
                run_next   = (in_byte == TAG_RUN);
                phase_next = PH_COUNT;
            end
            PH_COUNT: begin
                remaining_next = in_byte;
                if (run_reg) begin
                    phase_next = PH_VALUE;
                end else begin
                    phase_next = (in_byte == 8'd0) ? PH_TAG : PH_LIT;
                end
            end
            PH_VALUE: begin
                push_cmd.count = remaining_reg;
                addend         = remaining_reg;
                remaining_next = 8'd0;
                phase_next     = PH_TAG;
            end
            default: begin
                push_cmd.count = 8'd1;
                addend         = 8'd1;
                if (remaining_reg != 8'd0) begin
                    remaining_next = remaining_reg - 8'd1;
                end
                if (remaining_next == 8'd0) begin
                    phase_next = PH_TAG;
                end
            end
        endcase

        total_next = total_sat;

        if (last_byte) begin
            push_cmd.frame_end = 1'b1;
            priority if (phase_next == PH_COUNT) begin
                push_cmd.status = ST_CUT_HEADER;
            end else if (phase_next == PH_VALUE) begin
                push_cmd.status = ST_CUT_VALUE;
            end else if (phase_next == PH_LIT) begin
                push_cmd.status = ST_CUT_LITERAL;
            end else if (expected_reg != 32'd0 && total_next != expected_reg) begin
                push_cmd.status = ST_SIZE;
            end else begin
                push_cmd.status = ST_OK;
            end
            phase_next     = PH_TAG;
            run_next       = 1'b0;
            remaining_next = 8'd0;
            total_next     = 32'd0;
        end

        push = accept && ((push_cmd.count != 8'd0) || last_byte);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg  <= 32'd0;
            phase_reg     <= PH_TAG;
            run_reg       <= 1'b0;
            remaining_reg <= 8'd0;
            total_reg     <= 32'd0;
        end else begin
            if (cfg_we) begin
                expected_reg <= cfg_wdata;
            end
            if (accept) begin
                phase_reg     <= phase_next;
                run_reg       <= run_next;
                remaining_reg <= remaining_next;
                total_reg     <= total_next;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LIT) |-> (remaining_reg != 8'd0))
        else $error("literal phase with nothing owed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_byte) |=> (phase_reg == PH_TAG && total_reg == 32'd0))
        else $error("frame state not cleared after last byte");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !last_byte && phase_reg == PH_TAG) |-> !push)
        else $error("tag byte produced work");

endmodule

`default_nettype wire

FILE: rtl/rle_back.sv
`default_nettype none

module rle_back
    import rle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        head_cmd,
    input  wire logic        empty,
    output logic             pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_out_lanes,
    output logic [3:0]       m_lane_count,
    output logic             m_frame_end,
    output logic [2:0]       m_status
);

    localparam logic [7:0] GROUP_B = 8'(GROUP);

    logic [7:0]  left_reg, left_next;
    logic [7:0]  value_reg, value_next;
    logic        end_reg, end_next;
    logic [2:0]  status_reg, status_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] lanes_reg, lanes_next;
    logic [3:0]  count_reg, count_next;
    logic        fend_reg, fend_next;
    logic [2:0]  mstat_reg, mstat_next;
    logic        out_free;
    logic        step;
    logic [3:0]  n;
    logic [7:0]  left_after;
    logic        end_after;

    assign out_free = !m_valid_reg || m_ready;
    assign step     = out_free && ((left_reg != 8'd0) || end_reg);
    assign n        = (left_reg < GROUP_B) ? left_reg[3:0] : GROUP_B[3:0];

    always_comb begin
        left_after   = left_reg;
        end_after    = end_reg;
        m_valid_next = m_valid_reg && !m_ready;
        lanes_next   = lanes_reg;
        count_next   = count_reg;
        fend_next    = fend_reg;
        mstat_next   = mstat_reg;

        if (step) begin
            m_valid_next = 1'b1;
            if (left_reg != 8'd0) begin
                for (int i = 0; i < OUT_LANES; i++) begin
                    lanes_next[8*i +: 8] = (4'(i) < n) ? value_reg : 8'd0;
                end
                count_next = n;
                fend_next  = 1'b0;
                mstat_next = ST_OK;
                left_after = left_reg - {4'd0, n};
            end else begin
                lanes_next = 64'd0;
                count_next = 4'd0;
                fend_next  = 1'b1;
                mstat_next = status_reg;
                end_after  = 1'b0;
            end
        end

        pop         = (left_after == 8'd0) && !end_after && !empty;
        left_next   = pop ? head_cmd.count : left_after;
        end_next    = pop ? head_cmd.frame_end : end_after;
        value_next  = pop ? head_cmd.value : value_reg;
        status_next = pop ? head_cmd.status : status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= 8'd0;
            end_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            left_reg    <= left_next;
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        status_reg <= status_next;
        lanes_reg  <= lanes_next;
        count_reg  <= count_next;
        fend_reg   <= fend_next;
        mstat_reg  <= mstat_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_lanes  = lanes_reg;
    assign m_lane_count = count_reg;
    assign m_frame_end  = fend_reg;
    assign m_status     = mstat_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (fend_reg ? (count_reg == 4'd0)
                                  : (count_reg != 4'd0 && mstat_reg == ST_OK)))
        else $error("result beat mixes data and frame end");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (count_reg <= GROUP_B[3:0]))
        else $error("lane count above group size");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (left_reg != 8'd0 && out_free) |=> (left_reg == $past(left_reg) - {4'd0, $past(n)}
                                            || $past(pop)))
        else $error("run count did not advance");

endmodule

`default_nettype wire

FILE: rtl/rle_byte_decoder.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_in_byte[7:0], s_last_byte
// m_        out        m_valid / m_ready   m_out_lanes[63:0], m_lane_count[3:0],
//                                          m_frame_end, m_status[2:0]
// cfg       in         cfg_we              cfg_wdata[31:0] (expected size)
//
// The front end takes one input beat per cycle while its four-entry command
// queue has room. Tag and count bytes give no output; a literal byte costs the
// back end one output beat, a run value byte one beat per group of up to eight
// copies, and a frame end one further beat, so long runs set the sustained rate.
// Reset is synchronous on aresetn low and clears the parser, the queue and
// the output register; the expected size returns to zero.
// Either side may stall on its own: the queue and the output register
// decouple input acceptance from output back-pressure.
module rle_byte_decoder
    import rle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_out_lanes,
    output logic [3:0]       m_lane_count,
    output logic             m_frame_end,
    output logic [2:0]       m_status
);

    logic accept;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // An input beat is only taken when the queue can hold whatever it
    // produces; every byte yields at most one command.
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    rle_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (s_in_byte),
        .last_byte (s_last_byte),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    rle_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // The back end expands each command into lane groups and the closing
    // frame-end beat, holding each in its output register until taken.
    rle_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_cmd     (head_cmd),
        .empty        (q_empty),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_lanes  (m_out_lanes),
        .m_lane_count (m_lane_count),
        .m_frame_end  (m_frame_end),
        .m_status     (m_status)
    );

endmodule

`default_nettype wire

FILE: dv/rle_byte_decoder_checker.sv
module rle_byte_decoder_checker
    import rle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_out_lanes,
    input  logic [3:0]  m_lane_count,
    input  logic        m_frame_end,
    input  logic [2:0]  m_status,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [1:0] {
        WANT_TAG,
        WANT_COUNT,
        WANT_VALUE,
        WANT_LITERAL
    } parse_phase_e;

    typedef struct packed {
        logic [63:0] lanes;
        logic [3:0]  count;
        logic        frame_end;
        logic [2:0]  status;
    } out_beat_t;

    out_beat_t    decoded_beats[$];
    logic [31:0]  size_limit;
    parse_phase_e phase;
    logic         in_run;
    logic [7:0]   owed;
    logic [31:0]  byte_total;
    logic [2:0]   err;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t checker: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic clear_frame();
        phase      = WANT_TAG;
        in_run     = 1'b0;
        owed       = '0;
        byte_total = '0;
        err        = ST_OK;
    endtask

    task automatic add_bytes(input logic [31:0] n);
        if (32'hFFFF_FFFF - byte_total < n)
            byte_total = '1;
        else
            byte_total = byte_total + n;
    endtask

    task automatic push_beat(input logic [63:0] lanes, input logic [3:0] count,
                             input logic fend, input logic [2:0] status);
        out_beat_t b;
        b.lanes     = lanes;
        b.count     = count;
        b.frame_end = fend;
        b.status    = status;
        decoded_beats.push_back(b);
    endtask

    // Works out the beats that one accepted payload byte causes.
    task automatic decode_byte(input logic [7:0] b, input logic lst);
        logic [7:0]  left;
        logic [3:0]  n;
        logic [63:0] lanes;
        int          i;
        if (err == ST_OK) begin
            case (phase)
                WANT_TAG: begin
                    in_run = (b == TAG_RUN);
                    phase  = WANT_COUNT;
                end
                WANT_COUNT: begin
                    owed = b;
                    if (in_run)
                        phase = WANT_VALUE;
                    else
                        phase = (b == 8'd0) ? WANT_TAG : WANT_LITERAL;
                end
                WANT_VALUE: begin
                    left = owed;
                    while (left > 0) begin
                        n = (left < GROUP) ? 4'(left) : 4'(GROUP);
                        lanes = '0;
                        for (i = 0; i < n; i++)
                            lanes = lanes | (64'(b) << (8 * i));
                        push_beat(lanes, n, 1'b0, ST_OK);
                        left = left - 8'(n);
                    end
                    add_bytes(32'(owed));
                    owed  = '0;
                    phase = WANT_TAG;
                end
                default: begin
                    push_beat(64'(b), 4'd1, 1'b0, ST_OK);
                    add_bytes(32'd1);
                    if (owed > 0)
                        owed = owed - 8'd1;
                    if (owed == 0)
                        phase = WANT_TAG;
                end
            endcase
        end
        if (lst) begin
            if (err == ST_OK) begin
                if (phase == WANT_COUNT)
                    err = ST_CUT_HEADER;
                else if (phase == WANT_VALUE)
                    err = ST_CUT_VALUE;
                else if (phase == WANT_LITERAL)
                    err = ST_CUT_LITERAL;
                else if (size_limit != 0 && byte_total != size_limit)
                    err = ST_SIZE;
            end
            push_beat('0, 4'd0, 1'b1, err);
            clear_frame();
        end
    endtask

    task automatic check_beat();
        out_beat_t want;
        if (decoded_beats.size() == 0) begin
            report_mismatch("result beat with nothing expected", m_out_lanes, '0);
        end else begin
            want = decoded_beats.pop_front();
            if (m_out_lanes !== want.lanes)
                report_mismatch("out_lanes", m_out_lanes, want.lanes);
            if (m_lane_count !== want.count)
                report_mismatch("lane_count", 64'(m_lane_count), 64'(want.count));
            if (m_frame_end !== want.frame_end)
                report_mismatch("frame_end", 64'(m_frame_end), 64'(want.frame_end));
            if (m_status !== want.status)
                report_mismatch("status", 64'(m_status), 64'(want.status));
        end
    endtask

    // Input beats are taken before output beats so that an expectation is
    // always queued ahead of the beat that could satisfy it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            size_limit = '0;
            clear_frame();
            decoded_beats.delete();
            fail_count = 0;
        end else begin
            if (cfg_we)
                size_limit = cfg_wdata;
            if (s_valid && s_ready)
                decode_byte(s_in_byte, s_last_byte);
            if (m_valid && m_ready)
                check_beat();
        end
        pending = decoded_beats.size();
    end

endmodule

FILE: dv/rle_byte_decoder_tb.sv
module rle_byte_decoder_tb;
    import rle_pkg::*;

    // The random part stops once this many payload bytes have gone in.
    localparam int RANDOM_ITEMS = 430;
    // Cycles with no beat on either channel before the run is abandoned. The
    // longest honest quiet spell is a long stall plus the idle spell before a
    // register write, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 3000;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [31:0] cfg_wdata   = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte   = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [63:0] m_out_lanes;
    logic [3:0]  m_lane_count;
    logic        m_frame_end;
    logic [2:0]  m_status;

    int fail_count;
    int pending;

    // When calm is set neither side inserts gaps, giving stretches at full rate.
    bit         calm        = 1'b0;
    int         ready_hold  = 0;
    int         idle_cycles = 0;
    int         bytes_sent  = 0;
    logic [7:0] frame_bytes[$];

    always #5 aclk = ~aclk;

    rle_byte_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_lanes  (m_out_lanes),
        .m_lane_count (m_lane_count),
        .m_frame_end  (m_frame_end),
        .m_status     (m_status)
    );

    rle_byte_decoder_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_lanes  (m_out_lanes),
        .m_lane_count (m_lane_count),
        .m_frame_end  (m_frame_end),
        .m_status     (m_status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Gap lengths: mostly none or short, now and then a long one, so that
    // stalls land on every stage of a run or a literal packet.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Run lengths are mostly small; the odd long one forces the input to be
    // held off while the lane groups drain.
    function automatic int run_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 70)
            return $urandom_range(1, 16);
        if (r < 92)
            return $urandom_range(17, 64);
        if (r < 96)
            return 255;
        return $urandom_range(65, 254);
    endfunction

    // Any tag other than the run tag opens a literal packet.
    function automatic logic [7:0] literal_tag();
        logic [7:0] t;
        do
            t = 8'($urandom);
        while (t == TAG_RUN);
        return t;
    endfunction

    // The result side: m_ready is dropped for a random number of cycles and
    // then raised again, always at the falling edge.
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    // The watchdog only counts once reset is released, and any beat on
    // either channel restarts it.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[rle_byte_decoder] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one payload byte, after an optional gap, and returns at the
    // falling edge after it has been taken. Valid is left high so that a
    // back-to-back byte does not see it dropped and raised in one step.
    task automatic push_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_in_byte   <= b;
        s_last_byte <= lst;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Lets every expected beat come out, then gives the block a few spare
    // cycles before the size register is changed. Phases always end on a
    // frame end, so nothing is left half parsed at this point.
    task automatic write_expected_size(input logic [31:0] v);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Builds one random frame in frame_bytes. Most frames are well formed
    // sequences of run and literal packets; some are cut short inside the
    // last packet, and a few are plain noise. decoded is the byte count of
    // a well formed frame, and clean says whether the frame is one.
    task automatic build_frame(output int decoded, output bit clean);
        int         count;
        int         taken;
        logic [7:0] tag;
        frame_bytes.delete();
        decoded = 0;
        clean   = 1'b1;
        if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 10))
                frame_bytes.push_back(8'($urandom));
            clean = 1'b0;
            return;
        end
        repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 1) == 1) begin
                count = run_length();
                frame_bytes.push_back(TAG_RUN);
                frame_bytes.push_back(8'(count));
                frame_bytes.push_back(8'($urandom));
            end else begin
                count = $urandom_range(0, 6);
                frame_bytes.push_back(literal_tag());
                frame_bytes.push_back(8'(count));
                repeat (count)
                    frame_bytes.push_back(8'($urandom));
            end
            decoded += count;
        end
        if ($urandom_range(0, 99) < 12) begin
            // Cut the frame short inside a trailing packet: after its tag,
            // after a run count, or with literal bytes still owed.
            clean = 1'b0;
            case ($urandom_range(0, 2))
                0: frame_bytes.push_back(8'($urandom));
                1: begin
                    frame_bytes.push_back(TAG_RUN);
                    frame_bytes.push_back(8'($urandom));
                end
                default: begin
                    count = $urandom_range(1, 5);
                    taken = $urandom_range(0, count - 1);
                    tag   = literal_tag();
                    frame_bytes.push_back(tag);
                    frame_bytes.push_back(8'(count));
                    repeat (taken)
                        frame_bytes.push_back(8'($urandom));
                end
            endcase
        end
    endtask

    task automatic random_frame();
        int decoded;
        bit clean;
        build_frame(decoded, clean);
        send_frame();
        bytes_sent += frame_bytes.size();
    endtask

    initial begin
        int         decoded;
        bit         clean;
        logic [31:0] size_value;

        // Reset is held low from the start and released at a falling edge.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames. First the longest run, of the all-ones byte.
        frame_bytes = '{TAG_RUN, 8'hFF, 8'hFF};
        send_frame();
        // Literal packet with tag zero holding the bytes 00 and 80, a run that
        // spills into a second lane group, a zero-length run whose value byte
        // emits nothing, and a zero-length literal packet closing the frame.
        frame_bytes = '{8'h00, 8'h02, 8'h00, 8'h80, TAG_RUN, 8'd9, 8'hAA,
                        TAG_RUN, 8'd0, 8'h55, 8'hFF, 8'h00};
        send_frame();
        // Frame ends on a tag byte: the header is cut.
        frame_bytes = '{TAG_RUN};
        send_frame();
        // Frame ends on the count of a run: the value is cut.
        frame_bytes = '{TAG_RUN, 8'd5};
        send_frame();
        // Frame ends with literal bytes still owed; the one already sent
        // still leaves the block.
        frame_bytes = '{8'h02, 8'd3, 8'h7F};
        send_frame();
        // Size check: one byte short of the expected size, then an exact match.
        write_expected_size(32'd4);
        frame_bytes = '{TAG_RUN, 8'd3, 8'hC3};
        send_frame();
        write_expected_size(32'd3);
        frame_bytes = '{TAG_RUN, 8'd3, 8'h3C};
        send_frame();

        // Random phases, each under its own expected size setting.
        while (bytes_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: begin
                    write_expected_size(32'd0);
                    calm = ($urandom_range(0, 4) == 0);
                    repeat (3) random_frame();
                end
                1: begin
                    // The size is set for the one frame that follows, mostly
                    // exactly, sometimes one off either way.
                    build_frame(decoded, clean);
                    size_value = 32'(decoded);
                    if ($urandom_range(0, 3) == 0)
                        size_value = ($urandom_range(0, 1) == 1) ? size_value + 1
                                                                 : size_value - 1;
                    write_expected_size(size_value);
                    calm = ($urandom_range(0, 4) == 0);
                    send_frame();
                    bytes_sent += frame_bytes.size();
                end
                2: begin
                    write_expected_size(($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF
                                                                    : 32'd1);
                    calm = ($urandom_range(0, 4) == 0);
                    repeat (2) random_frame();
                end
                default: begin
                    write_expected_size(32'($urandom_range(1, 300)));
                    calm = ($urandom_range(0, 4) == 0);
                    repeat (3) random_frame();
                end
            endcase
        end

        // Drain: wait for every expected beat, then a short tail in which any
        // stray beat would still be caught.
        s_valid <= 1'b0;
        calm    = 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (fail_count == 0)
            $display("[rle_byte_decoder] OK");
        else
            $display("[rle_byte_decoder] ERROR");
        $finish;
    end

endmodule
